/* hw/rtl/lts_pkg.sv */
`timescale 1ns / 1ps

package lts_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned AngW  = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned IdxW  = 3;

  localparam logic [AngW-1:0]  MaxAngle     = 8'd180;
  localparam logic [WordW-1:0] RstPeriod    = 16'd20000;
  localparam logic [WordW-1:0] RstMinPulse  = 16'd500;
  localparam logic [WordW-1:0] RstSpan      = 16'd2000;
  localparam logic [WordW-1:0] RstThreshold = 16'd500;
  localparam logic [AngW-1:0]  RstBright    = 8'd180;
  localparam logic [AngW-1:0]  RstDark      = 8'd0;

  // x / 180 == (x >> 2) / 45; exact for (x >> 2) below 2^22 with ceil(2^28 / 45)
  localparam int unsigned     ProdW      = AngW + WordW;
  localparam int unsigned     QuarterW   = ProdW - 2;
  localparam int unsigned     RecipShift = 28;
  localparam int unsigned     RecipW     = 23;
  localparam logic [RecipW-1:0] Recip45  = 23'd5965233;
  localparam int unsigned     DivProdW   = QuarterW + RecipW + 1;

  typedef enum logic [CmdW-1:0] {
    CmdTick     = 2'd0,
    CmdSetAngle = 2'd1,
    CmdLight    = 2'd2
  } cmd_e;

  typedef enum logic [IdxW-1:0] {
    RegPeriod    = 3'd0,
    RegMinPulse  = 3'd1,
    RegSpan      = 3'd2,
    RegThreshold = 3'd3,
    RegBright    = 3'd4,
    RegDark      = 3'd5
  } reg_idx_e;

endpackage

/* hw/rtl/light_threshold_servo_pwm.sv */
// Pipeline: a request accepted into the v1_q stage moves through v2_q and v3_q to
// the output register vo_q, where its result is valid.
// Throughput: one request per cycle while out_stall_i is low; stages advance
// independently, so bubbles collapse and free stages fill while out_stall_i holds.
// Reset: config registers take their default values, the pin is low, counters clear,
// the requested width is 500 us, and the first tick starts a high phase.
`timescale 1ns / 1ps

module light_threshold_servo_pwm
  import lts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [AngW-1:0]   angle_i,
  input  logic [WordW-1:0]  light_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              servo_out_o,
  output logic              edge_res_o,
  output logic [WordW-1:0]  pulse_width_us_o
);

  logic [WordW-1:0] period_q, min_pulse_q, span_q, threshold_q;
  logic [AngW-1:0]  bright_q, dark_q;

  logic              v1_q, v2_q, v3_q, vo_q;
  logic [CmdW-1:0]   cmd1_q, cmd2_q, cmd3_q;
  logic [AngW-1:0]   ang1_q;
  logic [QuarterW-1:0] quarter2_q;
  logic [WordW-1:0]  quo3_q;

  logic              phase_high_q, phase_high_d;
  logic [WordW-1:0]  elapsed_q, elapsed_d;
  logic [WordW-1:0]  len_q, len_d;
  logic [WordW-1:0]  req_q, req_d;
  logic              edge_q, edge_d;

  logic ready_o, ready3, ready2, ready1;
  logic [AngW-1:0]     ang_sel, ang_clamp;
  logic [ProdW-1:0]    prod1;
  logic [DivProdW-1:0] prod2;
  logic [WordW:0]      width_sum;
  logic [WordW-1:0]    width_new;

  assign ready_o    = !vo_q || !out_stall_i;
  assign ready3     = !v3_q || ready_o;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  always_comb begin
    if (cmd_i == CmdLight) begin
      ang_sel = (light_i > threshold_q) ? bright_q : dark_q;
    end else begin
      ang_sel = angle_i;
    end
    ang_clamp = (ang_sel > MaxAngle) ? MaxAngle : ang_sel;
  end

  assign prod1 = {{WordW{1'b0}}, ang1_q} * {{AngW{1'b0}}, span_q};
  assign prod2 = {{(RecipW+1){1'b0}}, quarter2_q} * {{(QuarterW+1){1'b0}}, Recip45};

  assign width_sum = {1'b0, min_pulse_q} + {1'b0, quo3_q};
  assign width_new = width_sum[WordW] ? {WordW{1'b1}} : width_sum[WordW-1:0];

  always_comb begin
    phase_high_d = phase_high_q;
    elapsed_d    = elapsed_q;
    len_d        = len_q;
    req_d        = req_q;
    edge_d       = 1'b0;
    if (v3_q) begin
      case (cmd3_q)
        CmdTick: begin
          if (elapsed_q >= len_q) begin
            phase_high_d = !phase_high_q;
            edge_d       = 1'b1;
            elapsed_d    = WordW'(1);
            if (!phase_high_q) begin
              len_d = req_q;
            end else if (req_q >= period_q) begin
              len_d = WordW'(1);
            end else begin
              len_d = period_q - req_q;
            end
          end else begin
            elapsed_d = elapsed_q + WordW'(1);
          end
        end
        CmdSetAngle, CmdLight: begin
          req_d = width_new;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= RstPeriod;
      min_pulse_q <= RstMinPulse;
      span_q      <= RstSpan;
      threshold_q <= RstThreshold;
      bright_q    <= RstBright;
      dark_q      <= RstDark;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPeriod:    period_q    <= cfg_wdata_i;
        RegMinPulse:  min_pulse_q <= cfg_wdata_i;
        RegSpan:      span_q      <= cfg_wdata_i;
        RegThreshold: threshold_q <= cfg_wdata_i;
        RegBright:    bright_q    <= cfg_wdata_i[AngW-1:0];
        RegDark:      dark_q      <= cfg_wdata_i[AngW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      vo_q         <= 1'b0;
      phase_high_q <= 1'b0;
      elapsed_q    <= '0;
      len_q        <= '0;
      req_q        <= RstMinPulse;
      edge_q       <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready_o) begin
        vo_q         <= v3_q;
        edge_q       <= edge_d;
        phase_high_q <= phase_high_d;
        elapsed_q    <= elapsed_d;
        len_q        <= len_d;
        req_q        <= req_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      cmd1_q <= cmd_i;
      ang1_q <= ang_clamp;
    end
    if (ready2) begin
      cmd2_q     <= cmd1_q;
      quarter2_q <= prod1[ProdW-1:2];
    end
    if (ready3) begin
      cmd3_q <= cmd2_q;
      quo3_q <= prod2[RecipShift+WordW-1:RecipShift];
    end
  end

  assign out_valid_o      = vo_q;
  assign servo_out_o      = phase_high_q;
  assign edge_res_o       = edge_q;
  assign pulse_width_us_o = req_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input stalled with a free pipeline stage");

  a_elapsed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q <= len_q) || (elapsed_q == WordW'(1)))
    else $error("elapsed count ran past the phase length");

  a_low_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!phase_high_q && elapsed_q != '0) |-> (len_q != '0))
    else $error("low phase loaded with zero length");

  a_edge_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_q |-> vo_q)
    else $error("edge flag without a valid result");

  a_edge_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && v3_q && edge_d) |=> (phase_high_q != $past(phase_high_q)))
    else $error("edge reported without a pin toggle");

endmodule
